@@ rtl/core/hrc_pkg.sv @@
package hrc_pkg;

  localparam int WORD_W    = 38;
  localparam int SYN_W     = 6;
  localparam int CFG_W     = 3;
  localparam int MAX_BYTES = 4;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [WORD_W-1:0] word_in;
  } hrc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [SYN_W-1:0]  syndrome;
    logic              corrected;
    logic              syndrome_out_of_range;
  } hrc_out_t;

  function automatic bit is_pow2(int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // minimum r with 2^r >= k + r + 1
  function automatic int check_count(int k);
    int r;
    r = 0;
    while ((1 << r) < (k + r + 1)) r++;
    return r;
  endfunction

  function automatic int code_len(int m);
    return 8 * m + check_count(8 * m);
  endfunction

  // number of data positions ahead of position p
  function automatic int data_rank(int p);
    int cnt;
    cnt = 0;
    for (int q = 1; q < p; q++) begin
      if (!is_pow2(q)) cnt++;
    end
    return cnt;
  endfunction

  // codeword position that holds data bit i (0 = first data bit)
  function automatic int data_pos(int i);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p < 128; p++) begin
      if (!is_pow2(p)) begin
        if (cnt == i && pos == 0) pos = p;
        cnt++;
      end
    end
    return pos;
  endfunction

endpackage

@@ rtl/core/hamming_row_codec.sv @@
// Channel | Direction | Handshake                | Payload
// request | in        | in_valid_i / in_stall_o  | in_data_i  (hrc_in_t)
// result  | out       | out_valid_o / out_stall_i| out_data_o (hrc_out_t)
// config  | in        | cfg_we_i                 | cfg_wdata_i (bytes_per_row)
//
// Four register stages: input capture, syndrome XOR tree, correction or
// check-bit insertion, output pack. One request is taken per cycle while
// out_stall_i does not back the pipeline up.
// Reset clears all valid bits and sets bytes_per_row to 1.
// A stall holds only the stages that are full; bubbles still move forward.
module hamming_row_codec #(
  parameter int MaxBytes = hrc_pkg::MAX_BYTES
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  hrc_pkg::hrc_in_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output hrc_pkg::hrc_out_t       out_data_o,
  input  logic                    cfg_we_i,
  input  logic [hrc_pkg::CFG_W-1:0] cfg_wdata_i
);
  import hrc_pkg::*;

  localparam int NMax = code_len(MaxBytes);
  localparam int SynW = $clog2(NMax + 1);
  localparam int IdxW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

  logic [CFG_W-1:0] bpr_q;
  logic [IdxW-1:0]  sel_d;

  // row-size specific wiring
  wire [NMax:1]      enc_cand [MaxBytes];
  wire [NMax:1]      dec_cand [MaxBytes];
  wire [SynW-1:0]    n_cand   [MaxBytes];
  wire [WORD_W-1:0]  enc_out  [MaxBytes];
  wire [WORD_W-1:0]  dec_out  [MaxBytes];

  // stage 1
  logic            v1_q;
  op_e             op1_q;
  logic [IdxW-1:0] sel1_q;
  logic [SynW-1:0] n1_q;
  logic [NMax:1]   pos1_d, pos1_q;
  // stage 2
  logic            v2_q;
  op_e             op2_q;
  logic [IdxW-1:0] sel2_q;
  logic [SynW-1:0] n2_q;
  logic [NMax:1]   pos2_q;
  logic [SynW-1:0] syn2_d, syn2_q;
  // stage 3
  logic            v3_q;
  op_e             op3_q;
  logic [IdxW-1:0] sel3_q;
  logic [NMax:1]   pos3_d, pos3_q;
  logic [SynW-1:0] syn3_d, syn3_q;
  logic            corr3_d, corr3_q;
  logic            oor3_d, oor3_q;
  // output
  logic            vo_q;
  hrc_out_t        out_d, out_q;

  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3 = !vo_q || !out_stall_i;
  assign rdy2 = !v3_q || rdy3;
  assign rdy1 = !v2_q || rdy2;
  assign rdy0 = !v1_q || rdy1;
  assign in_stall_o  = !rdy0;
  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  for (genvar g = 0; g < MaxBytes; g++) begin : g_row
    localparam int K = 8 * (g + 1);
    localparam int N = code_len(g + 1);

    assign n_cand[g] = SynW'(N);

    for (genvar p = 1; p <= NMax; p++) begin : g_pos
      if (p <= N && (N - p) < WORD_W) begin : g_dec
        assign dec_cand[g][p] = in_data_i.word_in[N-p];
      end else begin : g_dec_zero
        assign dec_cand[g][p] = 1'b0;
      end
      if (p <= N && !is_pow2(p) && (K - 1 - data_rank(p)) < WORD_W) begin : g_enc
        assign enc_cand[g][p] = in_data_i.word_in[K-1-data_rank(p)];
      end else begin : g_enc_zero
        assign enc_cand[g][p] = 1'b0;
      end
    end

    for (genvar b = 0; b < WORD_W; b++) begin : g_bit
      if (N - b >= 1) begin : g_cw
        assign enc_out[g][b] = pos3_q[N-b];
      end else begin : g_cw_zero
        assign enc_out[g][b] = 1'b0;
      end
      if (b < K) begin : g_data
        assign dec_out[g][b] = pos3_q[data_pos(K-1-b)];
      end else begin : g_data_zero
        assign dec_out[g][b] = 1'b0;
      end
    end
  end

  // bytes_per_row of 0 acts as 1, above MaxBytes acts as MaxBytes
  always_comb begin
    priority if (bpr_q == '0) begin
      sel_d = '0;
    end else if (int'(bpr_q) > MaxBytes) begin
      sel_d = IdxW'(MaxBytes - 1);
    end else begin
      sel_d = IdxW'(int'(bpr_q) - 1);
    end
  end

  assign pos1_d = (in_data_i.operation == OP_DECODE) ? dec_cand[sel_d] : enc_cand[sel_d];

  always_comb begin
    syn2_d = '0;
    for (int p = 1; p <= NMax; p++) begin
      if (pos1_q[p]) syn2_d = syn2_d ^ SynW'(p);
    end
  end

  always_comb begin
    pos3_d  = pos2_q;
    syn3_d  = syn2_q;
    corr3_d = 1'b0;
    oor3_d  = 1'b0;
    if (op2_q == OP_ENCODE) begin
      // check positions are empty here, so the syndrome is the parity to insert
      for (int j = 0; j < SynW; j++) begin
        pos3_d[1<<j] = syn2_q[j];
      end
      syn3_d = '0;
    end else if (syn2_q != '0) begin
      if (syn2_q <= n2_q) begin
        for (int p = 1; p <= NMax; p++) begin
          if (syn2_q == SynW'(p)) pos3_d[p] = ~pos2_q[p];
        end
        corr3_d = 1'b1;
      end else begin
        oor3_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_d.result_word = (op3_q == OP_ENCODE) ? enc_out[sel3_q] : dec_out[sel3_q];
    out_d.syndrome    = SYN_W'(syn3_q);
    out_d.corrected   = corr3_q;
    out_d.syndrome_out_of_range = oor3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q <= CFG_W'(1);
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      if (cfg_we_i) bpr_q <= cfg_wdata_i;
      if (rdy0) v1_q <= in_valid_i;
      if (rdy1) v2_q <= v1_q;
      if (rdy2) v3_q <= v2_q;
      if (rdy3) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      op1_q  <= in_data_i.operation;
      sel1_q <= sel_d;
      n1_q   <= n_cand[sel_d];
      pos1_q <= pos1_d;
    end
    if (rdy1 && v1_q) begin
      op2_q  <= op1_q;
      sel2_q <= sel1_q;
      n2_q   <= n1_q;
      pos2_q <= pos1_q;
      syn2_q <= syn2_d;
    end
    if (rdy2 && v2_q) begin
      op3_q   <= op2_q;
      sel3_q  <= sel2_q;
      pos3_q  <= pos3_d;
      syn3_q  <= syn3_d;
      corr3_q <= corr3_d;
      oor3_q  <= oor3_d;
    end
    if (rdy3 && v3_q) begin
      out_q <= out_d;
    end
  end

endmodule

@@ test/tb_hamming_row_codec.sv @@
module tb_hamming_row_codec;
  timeunit 1ns;
  timeprecision 1ps;
  import hrc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int SHOW_LIMIT  = 10;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  hrc_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  hrc_out_t           out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;

  logic [CFG_W-1:0]   row_bytes_cfg = 3'd1;
  hrc_out_t           expected_rows[$];
  int                 mismatches    = 0;
  bit                 tx_idle_on    = 1'b1;
  bit                 rx_idle_on    = 1'b1;
  int                 rx_hold_req   = 0;
  int                 rx_hold_seen  = 0;
  int                 hold_left     = 0;

  hamming_row_codec dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // code length n for a row-size setting; 0 acts as 1, above MAX_BYTES clamps
  function automatic int code_bits(logic [CFG_W-1:0] cfg);
    int m;
    int r;
    m = int'(cfg);
    if (m < 1) m = 1;
    if (m > MAX_BYTES) m = MAX_BYTES;
    r = 0;
    while ((1 << r) < 8 * m + r + 1) r++;
    return 8 * m + r;
  endfunction

  function automatic hrc_out_t predict_row(op_e op, logic [WORD_W-1:0] w,
                                           logic [CFG_W-1:0] cfg);
    hrc_out_t          o;
    logic [WORD_W-1:0] res;
    logic [WORD_W-1:0] cw;
    int                n;
    int                d;
    int                s;
    n   = code_bits(cfg);
    res = '0;
    s   = 0;
    o   = '0;
    if (op == OP_ENCODE) begin
      d = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) d++;
      end
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          d--;
          res[n-p] = w[d];
        end
      end
      for (int p = 1; p <= n; p++) begin
        if (res[n-p]) s ^= p;
      end
      for (int p = 1; p <= n; p <<= 1) begin
        if ((s & p) != 0) res[n-p] = 1'b1;
      end
      o.result_word = res;
    end else begin
      cw = w;
      for (int p = 1; p <= n; p++) begin
        if (cw[n-p]) s ^= p;
      end
      if (s != 0) begin
        if (s <= n) begin
          cw[n-s]     = ~cw[n-s];
          o.corrected = 1'b1;
        end else begin
          o.syndrome_out_of_range = 1'b1;
        end
      end
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) res = {res[WORD_W-2:0], cw[n-p]};
      end
      o.result_word = res;
      o.syndrome    = s[SYN_W-1:0];
    end
    return o;
  endfunction

  function automatic void add_expected(hrc_out_t row);
    expected_rows = {expected_rows, row};
  endfunction

  function automatic logic [WORD_W-1:0] codeword_of(logic [WORD_W-1:0] data);
    hrc_out_t enc;
    enc = predict_row(OP_ENCODE, data, row_bytes_cfg);
    return enc.result_word;
  endfunction

  function automatic logic [WORD_W-1:0] with_error(logic [WORD_W-1:0] cw, int pos);
    return cw ^ ({{(WORD_W-1){1'b0}}, 1'b1} << (code_bits(row_bytes_cfg) - pos));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[WORD_W-1:0];
  endfunction

  task automatic send_request(op_e op, logic [WORD_W-1:0] w);
    hrc_in_t req;
    req.operation = op;
    req.word_in   = w;
    while (tx_idle_on && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    // accepted at the coming edge
    add_expected(predict_row(op, w, row_bytes_cfg));
    @(posedge clk_i);
  endtask

  task automatic wait_rows_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rows.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_row_bytes(logic [CFG_W-1:0] v);
    wait_rows_done();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    row_bytes_cfg = v;
    @(posedge clk_i);
  endtask

  task automatic test_reset_default();
    send_request(OP_ENCODE, '0);
    send_request(OP_ENCODE, '1);
    send_request(OP_DECODE, codeword_of(38'hA5));
    send_request(OP_DECODE, '1);
  endtask

  task automatic test_single_errors();
    logic [WORD_W-1:0] cw;
    set_row_bytes(3'd4);
    cw = codeword_of(rand_word());
    send_request(OP_DECODE, cw);
    send_request(OP_DECODE, with_error(cw, 1));
    send_request(OP_DECODE, with_error(cw, 17));
    send_request(OP_DECODE, with_error(cw, 32));
    send_request(OP_DECODE, with_error(cw, 38));
    // 1 ^ 38 points past the last position
    send_request(OP_DECODE, with_error(with_error(cw, 1), 38));
  endtask

  task automatic test_out_of_range();
    logic [WORD_W-1:0] cw;
    set_row_bytes(3'd1);
    cw = codeword_of(38'h3C);
    send_request(OP_DECODE, with_error(with_error(cw, 12), 1));
    send_request(OP_DECODE, with_error(with_error(cw, 12), 3));
    set_row_bytes(3'd3);
    cw = codeword_of(rand_word());
    send_request(OP_DECODE, with_error(with_error(cw, 29), 3));
    // bits above the code length must be ignored
    send_request(OP_DECODE, cw | ({WORD_W{1'b1}} << code_bits(row_bytes_cfg)));
  endtask

  task automatic test_row_size_clamp();
    set_row_bytes(3'd0);
    send_request(OP_ENCODE, '1);
    send_request(OP_DECODE, with_error(codeword_of(rand_word()), 7));
    set_row_bytes(3'd7);
    send_request(OP_ENCODE, '1);
    send_request(OP_DECODE, with_error(codeword_of(rand_word()), 5));
  endtask

  task automatic test_backpressure();
    set_row_bytes(3'd4);
    tx_idle_on = 1'b0;
    rx_hold_req++;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(1) == 0) send_request(OP_ENCODE, rand_word());
      else send_request(OP_DECODE, with_error(codeword_of(rand_word()),
                                              $urandom_range(38, 1)));
    end
    tx_idle_on = 1'b1;
    wait_rows_done();
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0]  plan[11] = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7,
                                    3'd4, 3'd5, 3'd1, 3'd6, 3'd3};
    logic [WORD_W-1:0] cw;
    logic [WORD_W-1:0] noise;
    int                n;
    int                sel;
    for (int ph = 0; ph < 11; ph++) begin
      set_row_bytes(plan[ph]);
      n          = code_bits(row_bytes_cfg);
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      for (int i = 0; i < 150; i++) begin
        sel   = $urandom_range(99);
        noise = rand_word();
        if (sel < 30) begin
          send_request(OP_ENCODE, noise);
        end else if (sel < 85) begin
          cw = codeword_of(rand_word());
          repeat ($urandom_range(2)) cw = with_error(cw, $urandom_range(n, 1));
          if ($urandom_range(1) == 0) cw |= noise & ~({WORD_W{1'b1}} >> (WORD_W - n));
          send_request(OP_DECODE, cw);
        end else begin
          send_request(OP_DECODE, noise);
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      hold_left    <= HOLD_CYCLES;
      out_stall_i  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_idle_on && ($urandom_range(99) < 16);
    end
  end

  always @(negedge clk_i) begin
    hrc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: unexpected result word=%h", $realtime, out_data_o.result_word);
      end else begin
        want = expected_rows.pop_front();
        if (out_data_o.result_word !== want.result_word ||
            out_data_o.syndrome !== want.syndrome ||
            out_data_o.corrected !== want.corrected ||
            out_data_o.syndrome_out_of_range !== want.syndrome_out_of_range) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: exp word=%h syn=%0d fix=%b oor=%b, got word=%h syn=%0d fix=%b oor=%b",
                     $realtime, want.result_word, want.syndrome, want.corrected,
                     want.syndrome_out_of_range, out_data_o.result_word,
                     out_data_o.syndrome, out_data_o.corrected,
                     out_data_o.syndrome_out_of_range);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_default();
    test_single_errors();
    test_out_of_range();
    test_row_size_clamp();
    test_backpressure();
    test_random_traffic();
    wait_rows_done();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
